// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the checker modules of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/iosrch_pkg.sv -----
// ----------------------------------------------------------------------------
// iosrch_pkg
// Types, sizes and codes shared by the interval overlap search modules.
// ----------------------------------------------------------------------------
package iosrch_pkg;

   // Number of intervals the table holds (1 to 64).
   localparam int CAPACITY = 64;
   // Width of the fill count and of the scan step counter.
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam int TIME_W = 64;
   localparam int ROW_W  = 32;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic signed [TIME_W-1:0] start_time;
      logic signed [TIME_W-1:0] end_time;
      logic [ROW_W-1:0]         row_id;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

endpackage

// ----- sv/interval_overlap_search.sv -----
// ----------------------------------------------------------------------------
// interval_overlap_search
// Table of closed time intervals with row ids, searched for overlaps.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          words per item
//   req_     in         req_valid/stall    one command word
//   rsp_     out        rsp_valid/stall    one per store, one or more per query
//
// A store returns a single word as soon as the result register is free.
// A query is accepted, rotates the ring of cells past the head comparator
// once in CAPACITY rotations and then sends its final word; rsp_stall on
// a full result register holds both the rotation and the final word.
// Reset clears the fill count and control; the stored intervals keep
// whatever they hold, since only slots below the fill count are reported.
//
// The intervals live in a ring of CAPACITY cells in insertion order, oldest
// in cell 0. A store writes the cell whose position equals the fill count.
// A query registers its range, then rotates the ring one position per cycle
// unless stalled, so every stored interval passes cell 0 in insertion order.
// The comparator looks at cell 0; slots at or above the fill count are
// ignored. After CAPACITY rotations every interval is back in its own cell.
//
// A match is held in a one-deep pending register until the next match is
// seen, which shows whether it was the last one. The pending match is then
// sent with last low, or, once the scan is over, with last high. A query
// with no match sends a single not-found word with last high.
// ----------------------------------------------------------------------------
module interval_overlap_search
   import iosrch_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_command,
   input  logic signed [TIME_W-1:0] req_start_time,
   input  logic signed [TIME_W-1:0] req_end_time,
   input  logic [ROW_W-1:0]         req_row_id,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ROW_W-1:0]         rsp_match_row,
   output logic                     rsp_found,
   output logic                     rsp_status,
   output logic                     rsp_last
);

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

   // Control state.
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic             pend_valid_ff, pend_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic signed [TIME_W-1:0] qs_ff, qs_in;
   logic signed [TIME_W-1:0] qe_ff, qe_in;
   logic [ROW_W-1:0]         pend_row_ff, pend_row_in;
   logic [ROW_W-1:0]         rsp_row_ff, rsp_row_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic                     rsp_status_ff, rsp_status_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic      accept;
   logic      out_free;
   logic      out_load;
   logic      is_full;
   logic      step_live;
   logic      head_hit;
   logic      shift_en;
   logic      store_en;
   entry_type new_entry;
   entry_type entries [CAPACITY];

   // The result register can take a new word when it is empty or its word
   // leaves in this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_full   = (cnt_ff >= FULL_CNT);
   assign step_live = (step_ff < cnt_ff);

   // A store needs the result register; a query only needs the block idle.
   assign req_stall = (state_ff != ST_IDLE) || ((req_command == CMD_STORE) && !out_free);
   assign accept    = req_valid && !req_stall;

   assign new_entry.start_time = req_start_time;
   assign new_entry.end_time   = req_end_time;
   assign new_entry.row_id     = req_row_id;

   // Ring of cells: each cell takes the interval of the cell above it, and
   // the top cell takes the one leaving cell 0.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type neighbor;

      if (i == CAPACITY - 1) begin : g_wrap
         assign neighbor = entries[0];
      end else begin : g_pass
         assign neighbor = entries[i+1];
      end

      iosrch_cell u_cell (
         .clock      (clock),
         .shift      (shift_en),
         .load       (store_en && (cnt_ff == CNT_W'(i))),
         .load_entry (new_entry),
         .next_entry (neighbor),
         .entry      (entries[i])
      );
   end

   iosrch_match u_match (
      .head     (entries[0]),
      .range_lo (qs_ff),
      .range_hi (qe_ff),
      .hit      (head_hit)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_QUERY)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (out_free && (step_ff == LAST_STEP)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath control and register updates.
   always_comb begin
      cnt_in        = cnt_ff;
      step_in       = step_ff;
      pend_valid_in = pend_valid_ff;
      pend_row_in   = pend_row_ff;
      qs_in         = qs_ff;
      qe_in         = qe_ff;
      shift_en      = 1'b0;
      store_en      = 1'b0;
      out_load      = 1'b0;
      rsp_row_in    = rsp_row_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_STORE)) begin
               // A full table drops the interval and reports it.
               out_load      = 1'b1;
               rsp_row_in    = '0;
               rsp_found_in  = 1'b0;
               rsp_status_in = is_full ? STATUS_FULL : STATUS_OK;
               rsp_last_in   = 1'b1;
               if (!is_full) begin
                  store_en = 1'b1;
                  cnt_in   = cnt_ff + 1'b1;
               end
            end else if (accept) begin
               qs_in         = req_start_time;
               qe_in         = req_end_time;
               step_in       = '0;
               pend_valid_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               shift_en = 1'b1;
               step_in  = step_ff + 1'b1;
               if (step_live && head_hit) begin
                  // A new match proves the pending one was not the last.
                  if (pend_valid_ff) begin
                     out_load      = 1'b1;
                     rsp_row_in    = pend_row_ff;
                     rsp_found_in  = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_row_in   = entries[0].row_id;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_row_in    = pend_valid_ff ? pend_row_ff : '0;
               rsp_found_in  = pend_valid_ff;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         step_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         step_ff       <= step_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qs_ff         <= qs_in;
      qe_ff         <= qe_in;
      pend_row_ff   <= pend_row_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_match_row = rsp_row_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ----- sv/iosrch_cell.sv -----
// ----------------------------------------------------------------------------
// iosrch_cell
// One slot of the interval ring: holds one stored interval, loads a new one
// on a store and takes its neighbor's interval when the ring rotates.
// ----------------------------------------------------------------------------
module iosrch_cell
   import iosrch_pkg::*;
(
   input  logic      clock,
   input  logic      shift,
   input  logic      load,
   input  entry_type load_entry,
   input  entry_type next_entry,
   output entry_type entry
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load) begin
         entry_in = load_entry;
      end else if (shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- sv/iosrch_match.sv -----
// ----------------------------------------------------------------------------
// iosrch_match
// Overlap test of the interval at the head of the ring against the query.
// ----------------------------------------------------------------------------
module iosrch_match
   import iosrch_pkg::*;
(
   input  entry_type                head,
   input  logic signed [TIME_W-1:0] range_lo,
   input  logic signed [TIME_W-1:0] range_hi,
   output logic                     hit
);

   // Closed intervals overlap when each starts no later than the other ends.
   assign hit = (head.start_time <= range_hi) && (head.end_time >= range_lo);

endmodule

// ----- sv/iosrch_checker.sv -----
// ----------------------------------------------------------------------------
// iosrch_checker
// Port-level checks of the result words of interval_overlap_search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iosrch_checker
   import iosrch_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [ROW_W-1:0] rsp_match_row,
   input logic             rsp_found,
   input logic             rsp_status,
   input logic             rsp_last
);

   // A stalled word stays on the port with row, found and last unchanged.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_match_row) && $stable(rsp_found) && $stable(rsp_last), "stalled result word changed")

   // A match word is never a refused store.
   `ASSERT_IMPLY(a_found_ok, clock, reset, rsp_valid && rsp_found, rsp_status == STATUS_OK, "match word carries full status")

   // A word without a match has a zero row and closes its item.
   `ASSERT_IMPLY(a_nomatch_last, clock, reset, rsp_valid && !rsp_found, (rsp_match_row == '0) && rsp_last, "word without match is not a final zero word")

   // A refused store answers with a single final word.
   `ASSERT_IMPLY(a_full_last, clock, reset, rsp_valid && (rsp_status == STATUS_FULL), rsp_last && !rsp_found, "full status on a non-final or match word")

endmodule

bind interval_overlap_search iosrch_checker u_iosrch_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_match_row (rsp_match_row),
   .rsp_found     (rsp_found),
   .rsp_status    (rsp_status),
   .rsp_last      (rsp_last)
);

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Interval overlap search testbench
// Stores intervals and queries overlaps through the request channel. Every
// accepted command word is run through a local copy of the interval table,
// and each reply word is checked field by field against the oldest
// prediction. Four phases idle neither, one or both of the two channels.
// ----------------------------------------------------------------------------
module testbench
   import iosrch_pkg::*;
();

   localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
   localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
   localparam int RANDOM_PER_PHASE = 111;
   localparam int CYCLE_LIMIT      = 1_500_000;
   localparam int REPORT_LIMIT     = 10;

   // One command word as the driver presents it on the request channel.
   typedef struct packed {
      logic                     command;
      logic signed [TIME_W-1:0] start_time;
      logic signed [TIME_W-1:0] end_time;
      logic [ROW_W-1:0]         row_id;
   } command_word_type;

   // One reply word as it leaves the block.
   typedef struct packed {
      logic [ROW_W-1:0] match_row;
      logic             found;
      logic             status;
      logic             last;
   } reply_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_command = CMD_STORE;
   logic signed [TIME_W-1:0] req_start_time = '0;
   logic signed [TIME_W-1:0] req_end_time = '0;
   logic [ROW_W-1:0]         req_row_id = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [ROW_W-1:0]         rsp_match_row;
   logic                     rsp_found;
   logic                     rsp_status;
   logic                     rsp_last;

   // Local copy of the interval table, updated as command words are accepted.
   logic signed [TIME_W-1:0] held_start [CAPACITY];
   logic signed [TIME_W-1:0] held_end [CAPACITY];
   logic [ROW_W-1:0]         held_row [CAPACITY];
   int                       held_count = 0;

   command_word_type pending_cmds[$];   // words waiting for the driver
   reply_word_type   due_words[$];      // predicted replies, oldest first
   command_word_type next_cmd;

   int words_launched = 0;   // written by the driver only
   int words_accepted = 0;   // written by the monitor only
   int send_idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;
   int cycle_count = 0;
   int replies_checked = 0;
   int stores_seen = 0;
   int stores_refused = 0;
   int queries_seen = 0;
   int matches_due = 0;
   int widest_reply = 0;

   int send_idle_by_phase [4] = '{0, 58, 0, 24};
   int stall_by_phase [4]     = '{0, 0, 58, 24};

   interval_overlap_search uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .req_row_id     (req_row_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_match_row  (rsp_match_row),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   always #1 clock = ~clock;

   // The run is cut off here if the block stops answering.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due", cycle_count,
                  due_words.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("[cycle %0d] %s", cycle_count, msg);
      end
   endtask

   // Appends a predicted reply word at the tail of the queue.
   task automatic queue_reply(input reply_word_type w);
      due_words.insert(due_words.size(), w);
   endtask

   // Appends a command word for the driver.
   task automatic queue_cmd(input command_word_type cw);
      pending_cmds.insert(pending_cmds.size(), cw);
   endtask

   // Applies one accepted command word to the local table and queues the
   // reply words it must produce. A store answers once, ok or full. A query
   // answers with every stored interval whose start is at or below the query
   // end and whose end is at or above the query start, in insertion order,
   // with last on the final one; a query with no hit answers a single
   // not-found word. Inverted ranges go through the same two comparisons.
   task automatic search_table(input logic cmd,
                               input logic signed [TIME_W-1:0] lo,
                               input logic signed [TIME_W-1:0] hi,
                               input logic [ROW_W-1:0] row);
      bit hit [CAPACITY];
      int hits = 0;
      int seen = 0;
      if (cmd == CMD_STORE) begin
         stores_seen++;
         if (held_count >= CAPACITY) begin
            // A full table drops the interval and leaves its state alone.
            stores_refused++;
            queue_reply('{match_row: '0, found: 1'b0, status: STATUS_FULL, last: 1'b1});
         end else begin
            held_start[held_count] = lo;
            held_end[held_count] = hi;
            held_row[held_count] = row;
            held_count++;
            queue_reply('{match_row: '0, found: 1'b0, status: STATUS_OK, last: 1'b1});
         end
      end else begin
         queries_seen++;
         for (int i = 0; i < held_count; i++) begin
            hit[i] = (held_start[i] <= hi) && (held_end[i] >= lo);
            if (hit[i]) hits++;
         end
         for (int i = 0; i < held_count; i++) begin
            if (hit[i]) begin
               seen++;
               queue_reply('{match_row: held_row[i], found: 1'b1,
                             status: STATUS_OK, last: (seen == hits)});
            end
         end
         if (hits == 0) begin
            queue_reply('{match_row: '0, found: 1'b0, status: STATUS_OK, last: 1'b1});
         end
         matches_due += hits;
         if (hits > widest_reply) widest_reply = hits;
      end
   endtask

   task automatic compare_reply(input reply_word_type got);
      reply_word_type want;
      replies_checked++;
      if (due_words.size() == 0) begin
         note_failure($sformatf("unexpected word: row=%h found=%b status=%b last=%b",
                                got.match_row, got.found, got.status, got.last));
      end else begin
         want = due_words.pop_front();
         if (got.match_row !== want.match_row || got.found !== want.found ||
             got.status !== want.status || got.last !== want.last) begin
            note_failure($sformatf({"reply %0d: expected row=%h found=%b status=%b ",
                                    "last=%b, got row=%h found=%b status=%b last=%b"},
                                   replies_checked, want.match_row, want.found,
                                   want.status, want.last, got.match_row, got.found,
                                   got.status, got.last));
         end
      end
   endtask

   function automatic command_word_type make_cmd(input logic cmd,
                                                 input logic signed [TIME_W-1:0] lo,
                                                 input logic signed [TIME_W-1:0] hi,
                                                 input logic [ROW_W-1:0] row);
      command_word_type cw;
      cw.command = cmd;
      cw.start_time = lo;
      cw.end_time = hi;
      cw.row_id = row;
      return cw;
   endfunction

   // Half the timestamps are drawn from small clusters, so that intervals
   // really overlap; the extremes, full-width values and values right
   // at the edges of stored intervals make up the rest.
   function automatic logic signed [TIME_W-1:0] pick_time();
      logic signed [TIME_W-1:0] t;
      logic signed [TIME_W-1:0] base;
      int offset;
      int slot;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(5))
               0: t = TIME_MIN;
               1: t = TIME_MAX;
               2: t = TIME_MIN + 1;
               3: t = TIME_MAX - 1;
               4: t = '0;
               default: t = '1;
            endcase
         end
         1, 2: begin
            t = {$urandom, $urandom};
         end
         3, 4: begin
            // Exactly on, or one step beside, a stored endpoint.
            if (held_count > 0) begin
               slot = $urandom_range(held_count - 1);
               offset = $urandom_range(2);
               t = ($urandom_range(1) ? held_start[slot] : held_end[slot]) + offset - 1;
            end else begin
               t = {$urandom, $urandom};
            end
         end
         default: begin
            case ($urandom_range(2))
               0: base = -64'sd1_000_000;
               1: base = '0;
               default: base = 64'sd5_000;
            endcase
            offset = $urandom_range(400);
            t = base + offset - 200;
         end
      endcase
      return t;
   endfunction

   function automatic logic [ROW_W-1:0] pick_row();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return (held_count > 0) ? held_row[$urandom_range(held_count - 1)] : $urandom;
         default: return $urandom;
      endcase
   endfunction

   // Stores are frequent until the table is full; after that only a few
   // more are sent, to keep checking the full answer.
   function automatic command_word_type make_random_cmd();
      command_word_type cw;
      int store_pct;
      int span;
      store_pct = (held_count < CAPACITY) ? 40 : 12;
      cw.command = ($urandom_range(99) < store_pct) ? CMD_STORE : CMD_QUERY;
      cw.row_id = pick_row();
      cw.start_time = pick_time();
      if (cw.command == CMD_QUERY && $urandom_range(9) == 0) begin
         // The whole time line, forward or inverted.
         if ($urandom_range(1)) begin
            cw.start_time = TIME_MIN;
            cw.end_time = TIME_MAX;
         end else begin
            cw.start_time = TIME_MAX;
            cw.end_time = TIME_MIN;
         end
      end else if ($urandom_range(3) != 0) begin
         span = ($urandom_range(3) == 0) ? $urandom_range(100000) : $urandom_range(300);
         cw.end_time = cw.start_time + span;
      end else begin
         cw.end_time = pick_time();
      end
      return cw;
   endfunction

   // Driver: inputs change on the falling edge. A word stays on the bus
   // until the monitor has seen it accepted; only then is the next word
   // taken from the queue, or the request side left idle.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (words_accepted == words_launched) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_cmd = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_command <= next_cmd.command;
               req_start_time <= next_cmd.start_time;
               req_end_time <= next_cmd.end_time;
               req_row_id <= next_cmd.row_id;
               words_launched++;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Monitor: both channels are sampled on the rising edge, where the
   // handshake completes.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            search_table(req_command, req_start_time, req_end_time, req_row_id);
            words_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            compare_reply('{match_row: rsp_match_row, found: rsp_found,
                            status: rsp_status, last: rsp_last});
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_idle_by_phase[phase];
         stall_pct = stall_by_phase[phase];

         if (phase == 0) begin
            // A query on the empty table finds nothing.
            queue_cmd(make_cmd(CMD_QUERY, TIME_MIN, TIME_MAX, $urandom));
            // Extremes of time and row id, an inverted interval, duplicates.
            queue_cmd(make_cmd(CMD_STORE, TIME_MIN, TIME_MAX, '1));
            queue_cmd(make_cmd(CMD_STORE, TIME_MIN, TIME_MIN, '0));
            queue_cmd(make_cmd(CMD_STORE, TIME_MAX, TIME_MAX, 32'd1));
            queue_cmd(make_cmd(CMD_STORE, 64'sd100, -64'sd100, 32'd2));
            queue_cmd(make_cmd(CMD_STORE, '0, '0, 32'd3));
            queue_cmd(make_cmd(CMD_STORE, '0, '0, 32'd3));
            queue_cmd(make_cmd(CMD_STORE, -64'sd1, 64'sd1, 32'hA5A5_A5A5));
            // Queries over the whole line, at each extreme, at a point, and
            // with inverted ranges; row ids on queries carry noise.
            queue_cmd(make_cmd(CMD_QUERY, TIME_MIN, TIME_MAX, '1));
            queue_cmd(make_cmd(CMD_QUERY, TIME_MIN, TIME_MIN, $urandom));
            queue_cmd(make_cmd(CMD_QUERY, TIME_MAX, TIME_MAX, $urandom));
            queue_cmd(make_cmd(CMD_QUERY, '0, '0, $urandom));
            queue_cmd(make_cmd(CMD_QUERY, 64'sd1, -64'sd1, $urandom));
            queue_cmd(make_cmd(CMD_QUERY, 64'sd101, 64'sd200, $urandom));
            queue_cmd(make_cmd(CMD_QUERY, -64'sd100, -64'sd100, $urandom));
            queue_cmd(make_cmd(CMD_QUERY, TIME_MAX, TIME_MIN, $urandom));
         end

         // Random words are generated just ahead of the driver, so that
         // edge values can be taken from intervals already stored.
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            while (pending_cmds.size() >= 2) @(posedge clock);
            queue_cmd(make_random_cmd());
         end

         while (pending_cmds.size() > 0 || words_accepted != words_launched ||
                due_words.size() > 0) begin
            @(posedge clock);
         end
      end

      // Quiet tail: a stray word after the last expected one is caught here.
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (2 * CAPACITY + 8) @(posedge clock);
      if (due_words.size() > 0) begin
         note_failure($sformatf("%0d expected words never arrived", due_words.size()));
      end

      $display("covered %0d commands: %0d stores (%0d refused, table full), %0d queries",
               words_accepted, stores_seen, stores_refused, queries_seen);
      $display("checked %0d reply words, %0d matches, widest answer %0d, %0d failures",
               replies_checked, matches_due, widest_reply, error_count);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
